>>> rtl/fbw_pkg.sv
// Shared types and constants for the packed mono framebuffer writer.
// No dependencies; every other file imports this package.
`default_nettype none

package fbw_pkg;

  // Field widths fixed by the item format
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 9;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned BIDX_W  = 14;
  localparam int unsigned SIZE_W  = 10;
  localparam int unsigned CADDR_W = 2;
  localparam int unsigned CDATA_W = 10;
  // Mapped index width: holds any product plus offset and any buffer depth
  localparam int unsigned IDX_W   = 17;
  localparam int unsigned PROD_W  = 16;
  localparam int unsigned HALF_W  = 8;

  localparam logic              ORIENT_RST = 1'b1;
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 10'd400;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 10'd300;

  // Leftmost pixel of a tile byte
  localparam logic [BYTE_W-1:0] PIX_MSB = 8'h80;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET  = 2'd0,
    KIND_FILL = 2'd1,
    KIND_READ = 2'd2
  } kind_e;

  typedef enum logic [CADDR_W-1:0] {
    CFG_ORIENT = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP,
    S_CHK,
    S_RD,
    S_MOD,
    S_FILL,
    S_DONE
  } state_e;

  // Registered result of the pixel address mapper
  typedef struct packed {
    logic             drop;
    logic [IDX_W-1:0] idx;
    logic [2:0]       code;
  } map_t;

endpackage

`default_nettype wire

>>> rtl/fbw_intf.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on fbw_pkg for field widths.
`default_nettype none

interface fbw_req_if import fbw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic [BYTE_W-1:0] value;
  logic [BIDX_W-1:0] byte_index;

  modport source (output valid, kind, pos_x, pos_y, value, byte_index, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, value, byte_index, output ready);
endinterface

interface fbw_rsp_if import fbw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [BYTE_W-1:0] read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

interface fbw_cfg_if import fbw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CADDR_W-1:0] addr;
  logic [CDATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> rtl/fbw_map.sv
// Pixel-to-byte address mapper: bounds check, one 8x8 multiply, offset add.
// Output registered on load_i. Depends on fbw_pkg.
`default_nettype none

module fbw_map import fbw_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 16384
) (
  input  wire logic              clk_i,
  input  wire logic              load_i,
  input  wire logic              orient_i,
  input  wire logic [SIZE_W-1:0] width_i,
  input  wire logic [SIZE_W-1:0] height_i,
  input  wire logic [POS_W-1:0]  pos_x_i,
  input  wire logic [POS_W-1:0]  pos_y_i,
  output map_t                   map_o
);

  logic [SIZE_W-1:0] x_ext, y_ext, inv_y;
  logic [HALF_W-1:0] mul_a, mul_b, offs;
  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  idx;
  logic [2:0]        code;
  logic              oob;
  map_t              map_d, map_q;

  always_comb begin
    x_ext = {1'b0, pos_x_i};
    y_ext = {1'b0, pos_y_i};
    oob   = (x_ext >= width_i) || (y_ext >= height_i);
    inv_y = height_i - SIZE_W'(1) - y_ext;
    if (orient_i) begin
      mul_a = pos_x_i[POS_W-1:1];
      mul_b = height_i[SIZE_W-1:2];
      offs  = inv_y[SIZE_W-1:2];
      code  = {inv_y[1:0], pos_x_i[0]};
    end else begin
      mul_a = pos_y_i[POS_W-1:1];
      mul_b = width_i[SIZE_W-1:2];
      offs  = {1'b0, pos_x_i[POS_W-1:2]};
      code  = {pos_x_i[1:0], pos_y_i[0]};
    end
    prod       = mul_a * mul_b;
    idx        = {1'b0, prod} + IDX_W'(offs);
    map_d.idx  = idx;
    map_d.code = code;
    map_d.drop = oob || (idx >= IDX_W'(BUFFER_BYTES));
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      map_q <= map_d;
    end
  end

  assign map_o = map_q;

endmodule

`default_nettype wire

>>> rtl/fbw_store.sv
// Single-port-write, single-port-read byte memory, registered read data.
// Depends on fbw_pkg for the byte width.
`default_nettype none

module fbw_store import fbw_pkg::*; #(
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [BYTE_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/packed_mono_framebuffer_writer_core.sv
// Set pixel runs map, check, read and modify; read runs read and modify; fill
// writes every byte; out-of-range read or unused kind goes straight to done. One item
// in flight at a time; the next request can be accepted while that response is valid.
// Fill is bounded by the single memory write port: one byte per cycle.
// Reset clears control and config (landscape, 400 x 300); the frame memory
// has no reset and no clearing pass.
`default_nettype none

module packed_mono_framebuffer_writer_core import fbw_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 16384
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fbw_req_if.sink     req_i,
  fbw_cfg_if.sink     cfg_i,
  fbw_rsp_if.source   rsp_o
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam logic [AW-1:0]    LAST_ADDR = AW'(BUFFER_BYTES - 1);
  localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(BUFFER_BYTES);

  // Config registers
  logic              orient_q;
  logic [SIZE_W-1:0] width_q, height_q;

  // Control
  state_e          state_q, state_d;
  logic [AW-1:0]   cnt_q, cnt_d;
  logic            st_q, st_d;

  // Captured request payload
  logic [KIND_W-1:0] kind_q;
  logic [POS_W-1:0]  pos_x_q, pos_y_q;
  logic [BYTE_W-1:0] value_q;
  logic [BIDX_W-1:0] bidx_q;

  // Response register
  logic              out_valid_q;
  logic              out_status_q;
  logic [BYTE_W-1:0] out_data_q;

  // Memory port and result strobes
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [BYTE_W-1:0] mem_wdata, mem_rdata;
  logic [BYTE_W-1:0] pix_mask, pix_byte;
  logic              slot_free, res_load, res_status, map_load, req_acc;
  logic [BYTE_W-1:0] res_data;
  map_t              map;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  // Response slot can take a new result when empty or being drained
  assign slot_free = !out_valid_q || rsp_o.ready;

  fbw_map #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_map (
    .clk_i   (clk_i),
    .load_i  (map_load),
    .orient_i(orient_q),
    .width_i (width_q),
    .height_i(height_q),
    .pos_x_i (pos_x_q),
    .pos_y_i (pos_y_q),
    .map_o   (map)
  );

  fbw_store #(
    .DEPTH(BUFFER_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Read-modify-write of one tile bit
  assign pix_mask = PIX_MSB >> map.code;
  assign pix_byte = (value_q != '0) ? (mem_rdata | pix_mask) : (mem_rdata & ~pix_mask);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    st_d       = st_q;
    map_load   = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = AW'(map.idx);
    mem_raddr  = AW'(map.idx);
    mem_wdata  = pix_byte;
    res_load   = 1'b0;
    res_status = st_q;
    res_data   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          st_d  = 1'b0;
          cnt_d = '0;
          if (req_i.kind == KIND_SET) begin
            state_d = S_MAP;
          end else if (req_i.kind == KIND_FILL) begin
            state_d = S_FILL;
          end else if (req_i.kind == KIND_READ &&
                       {3'b000, req_i.byte_index} < DEPTH_IDX) begin
            state_d = S_RD;
          end else begin
            // Unused kind, or a read beyond the buffer: answers zero
            state_d = S_DONE;
          end
        end
      end
      S_MAP: begin
        map_load = 1'b1;
        state_d  = S_CHK;
      end
      S_CHK: begin
        if (map.drop) begin
          st_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          mem_re  = 1'b1;
          state_d = S_MOD;
        end
      end
      S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(bidx_q);
        state_d   = S_MOD;
      end
      S_MOD: begin
        // Read data holds while the response slot is busy
        if (slot_free) begin
          mem_we   = (kind_q == KIND_SET);
          res_load = 1'b1;
          res_data = (kind_q == KIND_READ) ? mem_rdata : '0;
          state_d  = S_IDLE;
        end
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = value_q;
        cnt_d     = cnt_q + AW'(1);
        if (cnt_q == LAST_ADDR) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      st_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      st_q    <= st_d;
    end
  end

  // Request payload, captured on accept
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      kind_q  <= req_i.kind;
      pos_x_q <= req_i.pos_x;
      pos_y_q <= req_i.pos_y;
      value_q <= req_i.value;
      bidx_q  <= req_i.byte_index;
    end
  end

  // Config writes; indexes past the register list are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= ORIENT_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.addr == CFG_ORIENT) begin
        orient_q <= cfg_i.data[0];
      end
      if (cfg_i.addr == CFG_WIDTH) begin
        width_q <= cfg_i.data;
      end
      if (cfg_i.addr == CFG_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_status_q <= res_status;
      out_data_q   <= res_data;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.read_data = out_data_q;

  // A result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || rsp_o.ready))
    else $error("response overwritten before taken");

  // The modify step always follows a memory read issue
  a_mod_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD) |-> $past(mem_re || state_q == S_MOD))
    else $error("modify without preceding read");

  // Memory port never reads and writes in the same cycle
  a_port_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("memory read and write collide");

  // Fill sweep ends right after the last address
  a_fill_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL && cnt_q == LAST_ADDR) |=> (state_q == S_DONE))
    else $error("fill sweep did not end at last address");

endmodule

`default_nettype wire
